FILE: rtl/pbfa_pkg.sv
// Package for the payload bit-field allocator: request/result types,
// status and request codes, table entry layout and sizing constants.
// No dependencies.
package pbfa_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned TABLE_SLOTS_DEF   = 16;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;

  // Fixed geometry of a byte slot and of a field
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned MAX_FIELD_BITS = 16;
  localparam int unsigned FILL_W         = 4;   // fill count 0..8
  localparam int unsigned CMP_W          = 16;  // shared comparator width

  typedef enum logic [1:0] {
    REQ_DECLARE = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TABLE_FULL = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_EMPTY_KEY  = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_NO_SPACE   = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] tag_key;
    logic [4:0]  field_size;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [2:0] first_byte;
    logic [2:0] first_bit;
    logic       is_split;
    logic [2:0] second_byte;
    logic [2:0] second_bit;
    logic [4:0] width_bits;
  } res_t;

  // One table entry; byte indices are kept at reporting width
  typedef struct packed {
    logic [15:0] tag_key;
    logic [4:0]  width_bits;
    logic [2:0]  first_byte;
    logic [2:0]  first_bit;
    logic [2:0]  second_byte;
    logic [2:0]  second_bit;
  } tag_entry_t;

endpackage

FILE: rtl/payload_bit_field_allocator_core.sv
// Payload bit-field allocator, top level. Uses pbfa_pkg, pbfa_vmem, pbfa_cmp_unit.
// One request at a time: a new request is taken only in idle, after the last result
// has moved to the output register, which a held result can delay; one scan entry a cycle.
// Reset empties the table and fill counts through valid bits; no clearing pass.
module payload_bit_field_allocator_core #(
  parameter int unsigned TABLE_SLOTS   = pbfa_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned PAYLOAD_BYTES = pbfa_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pbfa_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbfa_pkg::res_t  out_res_o
);

  localparam int unsigned SW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned BW   = $clog2(PAYLOAD_BYTES);
  localparam int unsigned MAXD = (TABLE_SLOTS > PAYLOAD_BYTES) ? TABLE_SLOTS : PAYLOAD_BYTES;
  localparam int unsigned CW   = $clog2(MAXD);
  localparam int unsigned TW   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned FW   = pbfa_pkg::FILL_W;

  localparam logic [CW-1:0] SLOT_LAST = CW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0] BYTE_LAST = CW'(PAYLOAD_BYTES - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TSCAN  = 6'b000010,
    S_BSCAN  = 6'b000100,
    S_COMMIT = 6'b001000,
    S_FILL_B = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  // Build a result from a status and an entry; errors pass zeros
  function automatic pbfa_pkg::res_t make_res(input pbfa_pkg::status_e st,
                                              input logic [3:0] slot,
                                              input pbfa_pkg::tag_entry_t ent);
    pbfa_pkg::res_t r;
    r.status      = st;
    r.slot_index  = slot;
    r.first_byte  = ent.first_byte;
    r.first_bit   = ent.first_bit;
    r.is_split    = (ent.width_bits > 5'(pbfa_pkg::BYTE_BITS));
    r.second_byte = ent.second_byte;
    r.second_bit  = ent.second_bit;
    r.width_bits  = ent.width_bits;
    return r;
  endfunction

  // Control state
  state_e         state_q, state_d;
  logic           out_vld_q, out_vld_d;
  logic [TW-1:0]  total_q, total_d;
  logic           issue_q, issue_d;
  logic           chk_q, chk_d;
  logic           hit_q, hit_d;
  logic           free_q, free_d;
  logic           any_q, any_d;
  logic           odd_q, odd_d;
  logic           pass_b_q, pass_b_d;

  // Datapath registers
  pbfa_pkg::req_t     req_q, req_d;
  pbfa_pkg::res_t     wres_q, wres_d;
  pbfa_pkg::res_t     out_q, out_d;
  pbfa_pkg::tag_entry_t hit_ent_q, hit_ent_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  chk_idx_q, chk_idx_d;
  logic [SW-1:0]  hit_slot_q, hit_slot_d;
  logic [SW-1:0]  free_slot_q, free_slot_d;
  logic [BW-1:0]  any_idx_q, any_idx_d;
  logic [BW-1:0]  odd_idx_q, odd_idx_d;
  logic [FW-1:0]  any_fill_q, any_fill_d;
  logic [FW-1:0]  odd_fill_q, odd_fill_d;
  logic [BW-1:0]  a_idx_q, a_idx_d;
  logic [FW-1:0]  a_fill_q, a_fill_d;
  logic [BW-1:0]  b_idx_q, b_idx_d;
  logic [FW-1:0]  b_fill_q, b_fill_d;
  logic [FW-1:0]  need_q, need_d;

  // Memory and comparator hookup
  logic                 mem_clr;
  logic                 t_we;
  pbfa_pkg::tag_entry_t t_wdata;
  pbfa_pkg::tag_entry_t t_rdata;
  logic                 t_rvld;
  logic                 f_we;
  logic [BW-1:0]        f_waddr;
  logic [FW-1:0]        f_wdata;
  logic [FW-1:0]        f_rdata;
  logic                 f_rvld;
  logic [pbfa_pkg::CMP_W-1:0] cmp_a, cmp_b;
  logic                 cmp_eq, cmp_ge;

  // Request decode helpers
  logic [4:0]    size;
  logic          size_ok;
  logic          split;
  logic [FW-1:0] need_a;
  logic [FW-1:0] need_b;
  logic [FW-1:0] fill;
  logic [FW-1:0] room;
  logic [CW-1:0] scan_last;
  logic          scan_end;

  assign size    = req_q.field_size;
  assign size_ok = (size != 5'd0) && (size <= 5'(pbfa_pkg::MAX_FIELD_BITS));
  assign split   = (size > 5'(pbfa_pkg::BYTE_BITS));
  assign need_a  = split ? FW'(pbfa_pkg::BYTE_BITS) : size[FW-1:0];
  assign need_b  = FW'(size - 5'(pbfa_pkg::BYTE_BITS));

  // Fill of the byte under check; never-written bytes read as empty
  assign fill = f_rvld ? f_rdata : '0;
  assign room = FW'(pbfa_pkg::BYTE_BITS) - fill;

  assign scan_last = (state_q == S_TSCAN) ? SLOT_LAST : BYTE_LAST;
  assign scan_end  = chk_q && (chk_idx_q == scan_last);

  // Shared comparator operand select
  assign cmp_a = (state_q == S_TSCAN) ? t_rdata.tag_key : pbfa_pkg::CMP_W'(room);
  assign cmp_b = (state_q == S_TSCAN) ? req_q.tag_key   : pbfa_pkg::CMP_W'(need_q);

  pbfa_cmp_unit u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .eq_o (cmp_eq),
    .ge_o (cmp_ge)
  );

  pbfa_vmem #(
    .DEPTH (TABLE_SLOTS),
    .DW    ($bits(pbfa_pkg::tag_entry_t)),
    .AW    (SW)
  ) u_tag_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (t_we),
    .waddr_i (free_slot_q),
    .wdata_i (t_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (t_rdata),
    .rvld_o  (t_rvld)
  );

  pbfa_vmem #(
    .DEPTH (PAYLOAD_BYTES),
    .DW    (FW),
    .AW    (BW)
  ) u_fill_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (cnt_q[BW-1:0]),
    .rdata_o (f_rdata),
    .rvld_o  (f_rvld)
  );

  // New table entry, built from the scan results
  always_comb begin
    t_wdata             = '0;
    t_wdata.tag_key     = req_q.tag_key;
    t_wdata.width_bits  = size;
    t_wdata.first_byte  = 3'(a_idx_q);
    t_wdata.first_bit   = 3'(a_fill_q);
    t_wdata.second_byte = split ? 3'(b_idx_q) : 3'd0;
    t_wdata.second_bit  = split ? 3'(b_fill_q) : 3'd0;
  end

  assign t_we    = (state_q == S_COMMIT) && free_q;
  assign f_we    = t_we || (state_q == S_FILL_B);
  assign f_waddr = (state_q == S_FILL_B) ? b_idx_q : a_idx_q;
  assign f_wdata = (state_q == S_FILL_B) ? (b_fill_q + need_b) : (a_fill_q + need_a);
  assign mem_clr = (state_q == S_IDLE) && in_valid_i && (in_req_i.req_type == pbfa_pkg::REQ_CLEAR);

  // Sequencer
  always_comb begin
    logic          hit_n, free_n, any_n, odd_n, fit, sel_odd;
    logic [SW-1:0] hit_slot_n, free_slot_n;
    logic [BW-1:0] any_idx_n, odd_idx_n, sel_idx;
    logic [FW-1:0] any_fill_n, odd_fill_n, sel_fill;
    pbfa_pkg::tag_entry_t hit_ent_n;

    state_d     = state_q;
    out_vld_d   = out_vld_q;
    total_d     = total_q;
    issue_d     = issue_q;
    chk_d       = 1'b0;
    hit_d       = hit_q;
    free_d      = free_q;
    any_d       = any_q;
    odd_d       = odd_q;
    pass_b_d    = pass_b_q;
    req_d       = req_q;
    wres_d      = wres_q;
    out_d       = out_q;
    hit_ent_d   = hit_ent_q;
    cnt_d       = cnt_q;
    chk_idx_d   = cnt_q;
    hit_slot_d  = hit_slot_q;
    free_slot_d = free_slot_q;
    any_idx_d   = any_idx_q;
    odd_idx_d   = odd_idx_q;
    any_fill_d  = any_fill_q;
    odd_fill_d  = odd_fill_q;
    a_idx_d     = a_idx_q;
    a_fill_d    = a_fill_q;
    b_idx_d     = b_idx_q;
    b_fill_d    = b_fill_q;
    need_d      = need_q;

    // Running scan results including the entry under check
    hit_n       = hit_q;
    hit_slot_n  = hit_slot_q;
    hit_ent_n   = hit_ent_q;
    free_n      = free_q;
    free_slot_n = free_slot_q;
    any_n       = any_q;
    any_idx_n   = any_idx_q;
    any_fill_n  = any_fill_q;
    odd_n       = odd_q;
    odd_idx_n   = odd_idx_q;
    odd_fill_n  = odd_fill_q;
    fit         = cmp_ge && !(pass_b_q && (chk_idx_q[BW-1:0] == a_idx_q));
    sel_odd     = 1'b0;
    sel_idx     = '0;
    sel_fill    = '0;

    // Read issue: one address per cycle, checked the cycle after
    if (issue_q && (state_q inside {S_TSCAN, S_BSCAN})) begin
      chk_d = 1'b1;
      if (cnt_q == scan_last) begin
        issue_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end

    // Result register drains independently
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          cnt_d    = '0;
          issue_d  = 1'b1;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          pass_b_d = 1'b0;
          state_d  = S_DONE;
          case (in_req_i.req_type)
            pbfa_pkg::REQ_DECLARE: begin
              if (total_q >= TW'(TABLE_SLOTS)) begin
                wres_d = make_res(pbfa_pkg::ST_TABLE_FULL, '0, '0);
              end else if (in_req_i.tag_key == '0) begin
                wres_d = make_res(pbfa_pkg::ST_EMPTY_KEY, '0, '0);
              end else begin
                state_d = S_TSCAN;
              end
            end
            pbfa_pkg::REQ_LOOKUP: begin
              if (in_req_i.tag_key == '0) begin
                wres_d = make_res(pbfa_pkg::ST_NOT_FOUND, '0, '0);
              end else begin
                state_d = S_TSCAN;
              end
            end
            pbfa_pkg::REQ_CLEAR: begin
              total_d = '0;
              wres_d  = make_res(pbfa_pkg::ST_OK, '0, '0);
            end
            default: begin
              wres_d = make_res(pbfa_pkg::ST_OK, '0, '0);
            end
          endcase
        end
      end

      // Table scan: key match and lowest free slot in one pass
      S_TSCAN: begin
        if (chk_q) begin
          if (t_rvld && cmp_eq) begin
            hit_n      = 1'b1;
            hit_slot_n = chk_idx_q[SW-1:0];
            hit_ent_n  = t_rdata;
          end
          if (!t_rvld && !free_q) begin
            free_n      = 1'b1;
            free_slot_n = chk_idx_q[SW-1:0];
          end
        end
        hit_d       = hit_n;
        hit_slot_d  = hit_slot_n;
        hit_ent_d   = hit_ent_n;
        free_d      = free_n;
        free_slot_d = free_slot_n;
        if (scan_end) begin
          state_d = S_DONE;
          if (req_q.req_type == pbfa_pkg::REQ_LOOKUP) begin
            wres_d = hit_n ? make_res(pbfa_pkg::ST_OK, 4'(hit_slot_n), hit_ent_n)
                           : make_res(pbfa_pkg::ST_NOT_FOUND, '0, '0);
          end else if (hit_n) begin
            wres_d = make_res(pbfa_pkg::ST_DUPLICATE, '0, '0);
          end else if (!size_ok) begin
            wres_d = make_res(pbfa_pkg::ST_BAD_SIZE, '0, '0);
          end else begin
            state_d  = S_BSCAN;
            need_d   = need_a;
            pass_b_d = 1'b0;
            cnt_d    = '0;
            issue_d  = 1'b1;
            any_d    = 1'b0;
            odd_d    = 1'b0;
          end
        end
      end

      // Byte scan: first fitting byte and first fitting odd-room byte
      S_BSCAN: begin
        if (chk_q && fit) begin
          if (!any_q) begin
            any_n      = 1'b1;
            any_idx_n  = chk_idx_q[BW-1:0];
            any_fill_n = fill;
          end
          if (room[0] && !odd_q) begin
            odd_n      = 1'b1;
            odd_idx_n  = chk_idx_q[BW-1:0];
            odd_fill_n = fill;
          end
        end
        any_d      = any_n;
        any_idx_d  = any_idx_n;
        any_fill_d = any_fill_n;
        odd_d      = odd_n;
        odd_idx_d  = odd_idx_n;
        odd_fill_d = odd_fill_n;
        sel_odd    = need_q[0] && odd_n;
        sel_idx    = sel_odd ? odd_idx_n  : any_idx_n;
        sel_fill   = sel_odd ? odd_fill_n : any_fill_n;
        if (scan_end) begin
          if (!any_n) begin
            state_d = S_DONE;
            wres_d  = make_res(pbfa_pkg::ST_NO_SPACE, '0, '0);
          end else if (pass_b_q) begin
            b_idx_d  = sel_idx;
            b_fill_d = sel_fill;
            state_d  = S_COMMIT;
          end else begin
            a_idx_d  = sel_idx;
            a_fill_d = sel_fill;
            if (split) begin
              need_d   = need_b;
              pass_b_d = 1'b1;
              cnt_d    = '0;
              issue_d  = 1'b1;
              any_d    = 1'b0;
              odd_d    = 1'b0;
            end else begin
              state_d = S_COMMIT;
            end
          end
        end
      end

      // Write the entry and the first byte's fill, or report a full table if no slot is free
      S_COMMIT: begin
        if (!free_q) begin
          wres_d  = make_res(pbfa_pkg::ST_TABLE_FULL, '0, '0);
          state_d = S_DONE;
        end else begin
          total_d = total_q + TW'(1);
          wres_d  = make_res(pbfa_pkg::ST_OK, 4'(free_slot_q), t_wdata);
          state_d = split ? S_FILL_B : S_DONE;
        end
      end

      // Second byte's fill for a split field
      S_FILL_B: begin
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = wres_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      total_q   <= '0;
      issue_q   <= 1'b0;
      chk_q     <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      any_q     <= 1'b0;
      odd_q     <= 1'b0;
      pass_b_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      total_q   <= total_d;
      issue_q   <= issue_d;
      chk_q     <= chk_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      any_q     <= any_d;
      odd_q     <= odd_d;
      pass_b_q  <= pass_b_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    wres_q      <= wres_d;
    out_q       <= out_d;
    hit_ent_q   <= hit_ent_d;
    cnt_q       <= cnt_d;
    chk_idx_q   <= chk_idx_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    any_idx_q   <= any_idx_d;
    odd_idx_q   <= odd_idx_d;
    any_fill_q  <= any_fill_d;
    odd_fill_q  <= odd_fill_d;
    a_idx_q     <= a_idx_d;
    a_fill_q    <= a_fill_d;
    b_idx_q     <= b_idx_d;
    b_fill_q    <= b_fill_d;
    need_q      <= need_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // Entry count never exceeds the table
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(TABLE_SLOTS))
    else $error("entry count beyond table size");

  // A clear empties the entry count
  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.req_type == pbfa_pkg::REQ_CLEAR) |=> total_q == '0)
    else $error("entry count not zero after clear");

  // Error results carry no placement
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.status != pbfa_pkg::ST_OK) |->
      (out_res_o.width_bits == '0 && out_res_o.slot_index == '0 && !out_res_o.is_split))
    else $error("error result with nonzero placement");

  // Split flag agrees with the stored width
  a_split_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.is_split) |-> out_res_o.width_bits > 5'(pbfa_pkg::BYTE_BITS))
    else $error("split field of eight bits or less");

endmodule

FILE: rtl/pbfa_vmem.sv
// Single-port-write, registered-read memory with per-entry valid bits.
// Used for the tag table and the byte fill counts. Depends on nothing.
module pbfa_vmem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned DW    = 4,
  parameter int unsigned AW    = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          rvld_o
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DW-1:0]    rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  // Storage and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // Valid bits: cleared at once by reset or clear, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign rvld_o  = rvld_q;

endmodule

FILE: rtl/pbfa_cmp_unit.sv
// Shared comparator: key equality during the table scan and
// free-room versus need during the byte scans. Uses pbfa_pkg.
module pbfa_cmp_unit (
  input  logic [pbfa_pkg::CMP_W-1:0] a_i,
  input  logic [pbfa_pkg::CMP_W-1:0] b_i,
  output logic                       eq_o,
  output logic                       ge_o
);

  assign eq_o = (a_i == b_i);
  assign ge_o = (a_i >= b_i);

endmodule
